>>> hw/rtl/sqvs_pkg.sv
`default_nettype none

package sqvs_pkg;

    // Widest signed sine/cosine value: magnitude up to 2^24 at the largest fraction width.
    localparam int TrigW = 26;

    // pi/2 and sqrt(0.125), both Q30
    localparam longint unsigned HalfPiQ30 = 64'd1686629713;
    localparam logic signed [29:0] HalfRadiusQ30 = 30'sd379625062;

    // Taylor divisors (2n)(2n+1) for n = 1..7
    localparam int TaylorTerms = 7;
    localparam longint unsigned TaylorDiv [TaylorTerms] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
    };

    localparam int QDepth = 2;

    localparam logic [1:0] CornerFirst = 2'd0;
    localparam logic [1:0] CornerLast  = 2'd3;

    typedef struct packed {
        logic signed [31:0]      pos_x;
        logic signed [31:0]      pos_y;
        logic signed [31:0]      scale_x;
        logic signed [31:0]      scale_y;
        logic signed [TrigW-1:0] sin_v;
        logic signed [TrigW-1:0] cos_v;
        logic [31:0]             base;
        logic                    start;
        logic [15:0]             shader;
    } sqvs_quad_t;

    typedef struct packed {
        logic [1:0]  corner;
        logic [31:0] base;
        logic        start;
        logic [15:0] shader;
        logic        last;
    } sqvs_meta_t;

endpackage

`default_nettype wire

>>> hw/rtl/sprite_quad_vertex_setup_top.sv
`default_nettype none

// Sprite quad vertex setup. Each input beat is one quad command; the block
// returns four output beats, corners (-,-), (+,-), (-,+), (+,+), each rotated,
// offset by the centre and then scaled (the scale also applies to the centre),
// together with the batch base index, a new-batch flag on corner 0, the batch
// shader and a last-corner flag. The single corner datapath emits one vertex
// per cycle while the output is not stalled and a quad is queued. A beat passes
// the front register, the queue, stages 1 to 3 and the output register. Input
// beats are taken into a front register and a 2-entry queue, so the input side
// keeps accepting up to three quads ahead of the output.
module sprite_quad_vertex_setup_top
    import sqvs_pkg::*;
#(
    parameter int ANGLE_BITS       = 16,
    parameter int SINE_TABLE_DEPTH = 256,
    parameter int FRAC_BITS        = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [31:0] pos_x,
    input  wire logic signed [31:0] pos_y,
    input  wire logic [15:0]        rotation_angle,
    input  wire logic signed [31:0] scale_x,
    input  wire logic signed [31:0] scale_y,
    input  wire logic [15:0]        shader_id,
    input  wire logic               first_of_frame,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      vertex_x,
    output logic signed [31:0]      vertex_y,
    output logic [1:0]              corner_number,
    output logic [31:0]             base_index,
    output logic                    batch_start,
    output logic [15:0]             batch_shader,
    output logic                    last_corner
);

    logic       q_push;
    logic       q_full;
    logic       q_pop;
    logic       q_empty;
    sqvs_quad_t q_in;
    sqvs_quad_t q_out;

    sqvs_front #(
        .ANGLE_BITS       (ANGLE_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .FRAC_BITS        (FRAC_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .rotation_angle (rotation_angle),
        .scale_x        (scale_x),
        .scale_y        (scale_y),
        .shader_id      (shader_id),
        .first_of_frame (first_of_frame),
        .push           (q_push),
        .push_data      (q_in),
        .q_full         (q_full)
    );

    sqvs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    sqvs_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .entry         (q_out),
        .empty         (q_empty),
        .pop           (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .vertex_x      (vertex_x),
        .vertex_y      (vertex_y),
        .corner_number (corner_number),
        .base_index    (base_index),
        .batch_start   (batch_start),
        .batch_shader  (batch_shader),
        .last_corner   (last_corner)
    );

    a_batch_start_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && batch_start |-> corner_number == CornerFirst && base_index == 32'd0)
        else $error("batch start off corner 0 or with nonzero base");

    a_corner_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_corner |=>
            !out_valid || corner_number == 2'($past(corner_number) + 2'd1))
        else $error("corner order broken");

    a_base_steady: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_corner |=>
            !out_valid || base_index == $past(base_index))
        else $error("base index changed within a quad");

endmodule

`default_nettype wire

>>> hw/rtl/sqvs_front.sv
`default_nettype none

module sqvs_front
    import sqvs_pkg::*;
#(
    parameter int ANGLE_BITS       = 16,
    parameter int SINE_TABLE_DEPTH = 256,
    parameter int FRAC_BITS        = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [31:0] pos_x,
    input  wire logic signed [31:0] pos_y,
    input  wire logic [15:0]        rotation_angle,
    input  wire logic signed [31:0] scale_x,
    input  wire logic signed [31:0] scale_y,
    input  wire logic [15:0]        shader_id,
    input  wire logic               first_of_frame,
    output logic                    push,
    output sqvs_quad_t              push_data,
    input  wire logic               q_full
);

    localparam int IdxW = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int EntW = FRAC_BITS + 1;
    localparam int RW   = ANGLE_BITS - 2;
    localparam int SclW = RW + IdxW;
    localparam logic [ANGLE_BITS-1:0] Quarter = ANGLE_BITS'(1) << RW;

    typedef logic [SINE_TABLE_DEPTH:0][EntW-1:0] rom_t;

    function automatic longint unsigned sine_entry(input int k);
        longint unsigned x;
        longint unsigned term;
        longint          sum;
        x = (HalfPiQ30 * longint'(k)) / SINE_TABLE_DEPTH;
        term = x;
        sum = longint'(x);
        for (int n = 1; n <= TaylorTerms; n++)
        begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / TaylorDiv[n-1];
            if ((n % 2) == 1)
            begin
                sum = sum - longint'(term);
            end
            else
            begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0)
        begin
            sum = 0;
        end
        return ($unsigned(sum) + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    endfunction

    function automatic rom_t build_rom();
        rom_t rom;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++)
        begin
            rom[k] = EntW'(sine_entry(k));
        end
        return rom;
    endfunction

    localparam rom_t SineRom = build_rom();

    // {negate, mirrored table address}
    function automatic logic [IdxW:0] lookup(input logic [ANGLE_BITS-1:0] a);
        logic [SclW-1:0] scaled;
        logic [IdxW-1:0] idx;
        logic [IdxW-1:0] addr;
        scaled = SclW'(a[RW-1:0]) * SclW'(SINE_TABLE_DEPTH);
        idx = scaled[SclW-1:RW];
        addr = a[RW] ? (IdxW'(SINE_TABLE_DEPTH) - idx) : idx;
        return {a[ANGLE_BITS-1], addr};
    endfunction

    logic                    fire;
    logic                    fresh;
    logic [31:0]             base_next;
    logic [ANGLE_BITS-1:0]   ang_s;
    logic [ANGLE_BITS-1:0]   ang_c;
    logic [IdxW:0]           look_s;
    logic [IdxW:0]           look_c;

    logic                    open_reg;
    logic [15:0]             cur_shader_reg;
    logic [31:0]             count_reg;
    logic                    hold_valid_reg;
    logic                    hold_valid_next;

    logic signed [31:0]      pos_x_reg;
    logic signed [31:0]      pos_y_reg;
    logic signed [31:0]      scale_x_reg;
    logic signed [31:0]      scale_y_reg;
    logic [31:0]             base_reg;
    logic                    start_reg;
    logic [15:0]             shader_reg;
    logic [EntW-1:0]         sin_mag_reg;
    logic [EntW-1:0]         cos_mag_reg;
    logic                    sin_neg_reg;
    logic                    cos_neg_reg;

    assign in_stall = hold_valid_reg && q_full;
    assign fire     = in_valid && !in_stall;
    assign push     = hold_valid_reg && !q_full;

    assign fresh     = !open_reg || first_of_frame || (shader_id != cur_shader_reg);
    assign base_next = fresh ? 32'd0 : count_reg;

    assign ang_s  = ANGLE_BITS'(rotation_angle);
    assign ang_c  = ang_s + Quarter;
    assign look_s = lookup(ang_s);
    assign look_c = lookup(ang_c);

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (fire)
        begin
            hold_valid_next = 1'b1;
        end
        else if (push)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg       <= 1'b0;
            cur_shader_reg <= '0;
            count_reg      <= '0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            if (fire)
            begin
                open_reg       <= 1'b1;
                cur_shader_reg <= shader_id;
                count_reg      <= base_next + 32'd4;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            pos_x_reg   <= pos_x;
            pos_y_reg   <= pos_y;
            scale_x_reg <= scale_x;
            scale_y_reg <= scale_y;
            base_reg    <= base_next;
            start_reg   <= fresh;
            shader_reg  <= shader_id;
            sin_mag_reg <= SineRom[look_s[IdxW-1:0]];
            cos_mag_reg <= SineRom[look_c[IdxW-1:0]];
            sin_neg_reg <= look_s[IdxW];
            cos_neg_reg <= look_c[IdxW];
        end
    end

    always_comb
    begin
        push_data.pos_x   = pos_x_reg;
        push_data.pos_y   = pos_y_reg;
        push_data.scale_x = scale_x_reg;
        push_data.scale_y = scale_y_reg;
        push_data.sin_v   = sin_neg_reg ? -TrigW'(sin_mag_reg) : TrigW'(sin_mag_reg);
        push_data.cos_v   = cos_neg_reg ? -TrigW'(cos_mag_reg) : TrigW'(cos_mag_reg);
        push_data.base    = base_reg;
        push_data.start   = start_reg;
        push_data.shader  = shader_reg;
    end

endmodule

`default_nettype wire

>>> hw/rtl/sqvs_queue.sv
`default_nettype none

module sqvs_queue
    import sqvs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire sqvs_quad_t push_data,
    output logic            full,
    input  wire logic       pop,
    output sqvs_quad_t      pop_data,
    output logic            empty
);

    localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
    localparam int CntW = $clog2(QDepth + 1);

    sqvs_quad_t      mem_reg [QDepth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;

    assign full     = count_reg == CntW'(QDepth);
    assign empty    = count_reg == '0;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + CntW'(1);
            2'b01:   count_next = count_reg - CntW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(QDepth - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(QDepth - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/sqvs_back.sv
`default_nettype none

module sqvs_back
    import sqvs_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire sqvs_quad_t         entry,
    input  wire logic               empty,
    output logic                    pop,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      vertex_x,
    output logic signed [31:0]      vertex_y,
    output logic [1:0]              corner_number,
    output logic [31:0]             base_index,
    output logic                    batch_start,
    output logic [15:0]             batch_shader,
    output logic                    last_corner
);

    localparam int UW    = TrigW + 1;
    localparam int ProdW = UW + 30;

    logic                    adv;
    logic                    issue;
    logic [1:0]              corner_reg;
    logic signed [UW-1:0]    ce;
    logic signed [UW-1:0]    se;
    logic signed [UW-1:0]    ux;
    logic signed [UW-1:0]    uy;
    sqvs_meta_t              meta_next;

    // stage 1: corner offset times radius
    logic                    s1_valid_reg;
    logic signed [ProdW-1:0] s1_px_reg;
    logic signed [ProdW-1:0] s1_py_reg;
    logic signed [31:0]      s1_pos_x_reg;
    logic signed [31:0]      s1_pos_y_reg;
    logic signed [31:0]      s1_scx_reg;
    logic signed [31:0]      s1_scy_reg;
    sqvs_meta_t              s1_meta_reg;

    // stage 2: rounded offset plus centre
    logic signed [ProdW-1:0] rnd_x;
    logic signed [ProdW-1:0] rnd_y;
    logic                    s2_valid_reg;
    logic signed [31:0]      s2_qx_reg;
    logic signed [31:0]      s2_qy_reg;
    logic signed [31:0]      s2_scx_reg;
    logic signed [31:0]      s2_scy_reg;
    sqvs_meta_t              s2_meta_reg;

    // stage 3: scale product
    logic                    s3_valid_reg;
    logic signed [63:0]      s3_mx_reg;
    logic signed [63:0]      s3_my_reg;
    sqvs_meta_t              s3_meta_reg;

    // output register
    logic signed [63:0]      fin_x;
    logic signed [63:0]      fin_y;
    logic                    out_valid_reg;
    logic signed [31:0]      vx_reg;
    logic signed [31:0]      vy_reg;
    sqvs_meta_t              out_meta_reg;

    assign adv   = !out_valid_reg || !out_stall;
    assign issue = !empty && adv;
    assign pop   = issue && (corner_reg == CornerLast);

    assign ce = UW'(entry.cos_v);
    assign se = UW'(entry.sin_v);
    assign ux = (corner_reg[0] ? ce : -ce) + (corner_reg[1] ? -se : se);
    assign uy = (corner_reg[0] ? se : -se) + (corner_reg[1] ? ce : -ce);

    always_comb
    begin
        meta_next.corner = corner_reg;
        meta_next.base   = entry.base;
        meta_next.start  = entry.start && (corner_reg == CornerFirst);
        meta_next.shader = entry.shader;
        meta_next.last   = corner_reg == CornerLast;
    end

    assign rnd_x = s1_px_reg + (ProdW'(1) << 29);
    assign rnd_y = s1_py_reg + (ProdW'(1) << 29);

    assign fin_x = s3_mx_reg + (64'sd1 <<< (FRAC_BITS - 1));
    assign fin_y = s3_my_reg + (64'sd1 <<< (FRAC_BITS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner_reg    <= CornerFirst;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            if (issue)
            begin
                corner_reg <= corner_reg + 2'd1;
            end
            s1_valid_reg  <= issue;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_px_reg    <= ProdW'(ux) * ProdW'(HalfRadiusQ30);
            s1_py_reg    <= ProdW'(uy) * ProdW'(HalfRadiusQ30);
            s1_pos_x_reg <= entry.pos_x;
            s1_pos_y_reg <= entry.pos_y;
            s1_scx_reg   <= entry.scale_x;
            s1_scy_reg   <= entry.scale_y;
            s1_meta_reg  <= meta_next;

            s2_qx_reg   <= s1_pos_x_reg + 32'(rnd_x >>> 30);
            s2_qy_reg   <= s1_pos_y_reg + 32'(rnd_y >>> 30);
            s2_scx_reg  <= s1_scx_reg;
            s2_scy_reg  <= s1_scy_reg;
            s2_meta_reg <= s1_meta_reg;

            s3_mx_reg   <= 64'(s2_qx_reg) * 64'(s2_scx_reg);
            s3_my_reg   <= 64'(s2_qy_reg) * 64'(s2_scy_reg);
            s3_meta_reg <= s2_meta_reg;

            vx_reg       <= fin_x[FRAC_BITS+31:FRAC_BITS];
            vy_reg       <= fin_y[FRAC_BITS+31:FRAC_BITS];
            out_meta_reg <= s3_meta_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign vertex_x      = vx_reg;
    assign vertex_y      = vy_reg;
    assign corner_number = out_meta_reg.corner;
    assign base_index    = out_meta_reg.base;
    assign batch_start   = out_meta_reg.start;
    assign batch_shader  = out_meta_reg.shader;
    assign last_corner   = out_meta_reg.last;

endmodule

`default_nettype wire
